[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("next-cycle implication failed");

`endif

[hw/rtl/lfgr_pkg.sv]
// Types, codes and constants of the lagged Fibonacci gaussian generator.
package lfgr_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_UNIF  = 2'd1;
  localparam logic [1:0] OP_GAUSS = 2'd2;

  localparam int unsigned LAG_LONG  = 2281;
  localparam int unsigned LAG_SHORT = 1252;

  localparam logic [63:0] Q30 = 64'd1073741824;
  localparam logic [30:0] TWO_LN2_Q30 =
    31'((64'd13862943611 * Q30 + 64'd5000000000) / 64'd10000000000);
  localparam logic [32:0] TWO_PI_Q30 =
    33'((64'd6283185307 * Q30 + 64'd500000000) / 64'd1000000000);
  localparam logic [33:0] CORDIC_GAIN_Q30 =
    34'((64'd6072529350 * Q30 + 64'd5000000000) / 64'd10000000000);

  localparam int CORDIC_STEPS = 24;
  localparam int LOG_ROUNDS   = 30;
  localparam int SQRT_ROUNDS  = 22;

  localparam logic signed [26:0] OUT_MAX = 27'sd8388607;
  localparam logic signed [26:0] OUT_MIN = -27'sd8388608;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] seed_index;
    logic [63:0] seed_value;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [63:0]        uniform_word;
    logic [30:0]        scaled_value;
    logic signed [23:0] gauss_first;
    logic signed [23:0] gauss_second;
  } result_t;

  typedef struct packed {
    logic       latch;
    logic       load_wr;
    logic       rd_a;
    logic       rd_b;
    logic       sum;
    logic       sum_w2;
    logic       clamp;
    logic       mul0;
    logic       mul1;
    logic       emit_u;
    logic       norm;
    logic       log_step;
    logic       len;
    logic       pmul;
    logic       iter;
    logic       sqrt_en;
    logic [4:0] step;
    logic       fin0;
    logic       fin1;
    logic       emit_g;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
  } status_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [33:0] cordic_atan(input logic [4:0] i);
    logic [63:0] d;
    case (i)
      5'd0:  d = 64'd7853981634;
      5'd1:  d = 64'd4636476090;
      5'd2:  d = 64'd2449786631;
      5'd3:  d = 64'd1243549945;
      5'd4:  d = 64'd624188100;
      5'd5:  d = 64'd312398334;
      5'd6:  d = 64'd156237286;
      5'd7:  d = 64'd78123411;
      5'd8:  d = 64'd39062301;
      5'd9:  d = 64'd19531225;
      5'd10: d = 64'd9765622;
      5'd11: d = 64'd4882812;
      default: d = 64'd0;
    endcase
    if (i < 5'd12) begin
      return $signed(34'((d * Q30 + 64'd5000000000) / 64'd10000000000));
    end
    return $signed(34'(34'd1 << (5'd30 - i)));
  endfunction

endpackage

[hw/rtl/lfgr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lfgr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and register the read word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lfgr_ctrl.sv]
// Controller state machine sequencing loads, draws and the gaussian units.
module lfgr_ctrl import lfgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] op_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_MUL0  = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_EMITU = 4'd7;
  localparam logic [3:0] S_NORM  = 4'd8;
  localparam logic [3:0] S_LOG   = 4'd9;
  localparam logic [3:0] S_LEN   = 4'd10;
  localparam logic [3:0] S_PMUL  = 4'd11;
  localparam logic [3:0] S_ITER  = 4'd12;
  localparam logic [3:0] S_FIN0  = 4'd13;
  localparam logic [3:0] S_FIN1  = 4'd14;
  localparam logic [3:0] S_FIN2  = 4'd15;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       gauss_q, gauss_d;
  logic       second_q, second_d;

  // Sequence the datapath.
  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    cnt_d    = cnt_q;
    gauss_d  = gauss_q;
    second_d = second_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          second_d    = 1'b0;
          cnt_d       = '0;
          case (op_i)
            OP_LOAD:  state_d = S_LOAD;
            OP_UNIF: begin
              gauss_d = 1'b0;
              state_d = S_RDA;
            end
            OP_GAUSS: begin
              gauss_d = 1'b1;
              state_d = S_RDA;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        if (!gauss_q) begin
          state_d = S_MUL0;
        end else if (!second_q) begin
          cmd_o.clamp = 1'b1;
          second_d    = 1'b1;
          state_d     = S_RDA;
        end else begin
          cmd_o.sum_w2 = 1'b1;
          state_d      = S_NORM;
        end
      end
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_EMITU;
      end
      S_EMITU: begin
        cmd_o.emit_u = 1'b1;
        state_d      = S_IDLE;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        if (status_i.norm_done) begin
          cnt_d   = '0;
          state_d = S_LOG;
        end
      end
      S_LOG: begin
        cmd_o.log_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'(LOG_ROUNDS - 1)) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.len = 1'b1;
        state_d   = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.pmul = 1'b1;
        cnt_d      = '0;
        state_d    = S_ITER;
      end
      S_ITER: begin
        cmd_o.iter    = 1'b1;
        cmd_o.step    = cnt_q;
        cmd_o.sqrt_en = (cnt_q < 5'(SQRT_ROUNDS));
        cnt_d         = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
          state_d = S_FIN0;
        end
      end
      S_FIN0: begin
        cmd_o.fin0 = 1'b1;
        state_d    = S_FIN1;
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.emit_g = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      gauss_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      gauss_q  <= gauss_d;
      second_q <= second_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hw/rtl/lfgr_dpath.sv]
// Datapath: ring pointer, ring RAM, scaling multiplier, log, sqrt and CORDIC.
module lfgr_dpath import lfgr_pkg::*; #(
  parameter int RING_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  item_t       item_i,
  input  logic        cfg_valid_i,
  input  logic [30:0] cfg_data_i,
  output status_t     status_o,
  output logic        result_valid_o,
  output result_t     result_o
);

  localparam int PW = $clog2(RING_DEPTH);

  logic [PW-1:0] ptr_q;
  logic [PW-1:0] addr_a, addr_b, raddr, waddr;
  logic [PW:0]   tmp_a, tmp_b;
  logic [63:0]   rdata, wdata, sum_w;
  logic          we;

  item_t        item_q;
  logic [63:0]  wa_q, w1_q, w2_q;
  logic [5:0]   n_q;
  logic [31:0]  x_q;
  logic [29:0]  f_q;
  logic [36:0]  l_q;
  logic [63:0]  prod_q, acc_q;
  logic [43:0]  v_q, res_q, bit_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic signed [56:0] gm_q;
  logic signed [23:0] g1_q;
  logic [30:0]  scale_q;
  result_t      out_q;
  logic         valid_q;

  logic [63:0]  sq;
  logic [32:0]  sq_sh;
  logic [61:0]  pl;
  logic [62:0]  zp;
  logic [43:0]  trial;
  logic signed [33:0] dx, dy, at, c_sel, s_sel;
  logic signed [22:0] rad_s;
  logic signed [56:0] gm_d;
  logic signed [23:0] g_sat;

  // Form lag addresses behind the write pointer.
  always_comb begin
    tmp_a = {1'b0, ptr_q} + (PW+1)'(RING_DEPTH - LAG_LONG);
    if (tmp_a >= (PW+1)'(RING_DEPTH)) tmp_a = tmp_a - (PW+1)'(RING_DEPTH);
    tmp_b = {1'b0, ptr_q} + (PW+1)'(RING_DEPTH - LAG_SHORT);
    if (tmp_b >= (PW+1)'(RING_DEPTH)) tmp_b = tmp_b - (PW+1)'(RING_DEPTH);
    addr_a = tmp_a[PW-1:0];
    addr_b = tmp_b[PW-1:0];
  end

  assign sum_w = wa_q + rdata;
  assign raddr = cmd_i.rd_b ? addr_b : addr_a;
  assign waddr = cmd_i.load_wr ? PW'(item_q.seed_index) : ptr_q;
  assign wdata = cmd_i.load_wr ? item_q.seed_value : sum_w;
  assign we    = cmd_i.load_wr | cmd_i.sum;

  lfgr_ram #(.WIDTH(64), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Arithmetic for one step of each iterative unit.
  always_comb begin
    sq    = {32'b0, x_q} * {32'b0, x_q};
    sq_sh = sq[63:31];
    pl    = {31'b0, l_q[36:6]} * {31'b0, TWO_LN2_Q30};
    zp    = {33'b0, w2_q[61:32]} * {30'b0, TWO_PI_Q30};
    trial = res_q + bit_q;
    dx    = cy_q >>> cmd_i.step;
    dy    = cx_q >>> cmd_i.step;
    at    = cordic_atan(cmd_i.step);
    case (w2_q[63:62])
      2'd0: begin c_sel = cx_q;  s_sel = cy_q;  end
      2'd1: begin c_sel = -cy_q; s_sel = cx_q;  end
      2'd2: begin c_sel = -cx_q; s_sel = -cy_q; end
      default: begin c_sel = cy_q; s_sel = -cx_q; end
    endcase
    rad_s = $signed({1'b0, res_q[21:0]});
    gm_d  = 57'(rad_s) * 57'(cmd_i.fin0 ? c_sel : s_sel);
  end

  // Round the scaled product and saturate to 24 bits.
  function automatic logic signed [23:0] round_sat(input logic signed [56:0] p);
    logic signed [56:0] r;
    logic signed [26:0] t;
    r = (p + 57'sd536870912) >>> 30;
    t = r[26:0];
    if (r > 57'(OUT_MAX)) return OUT_MAX[23:0];
    if (r < 57'(OUT_MIN)) return OUT_MIN[23:0];
    return t[23:0];
  endfunction

  assign g_sat = round_sat(gm_q);

  // Advance the datapath registers on each command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
      n_q    <= '0;
    end
    if (cmd_i.rd_b) wa_q <= rdata;
    if (cmd_i.sum) begin
      if (cmd_i.sum_w2) w2_q <= sum_w;
      else if (cmd_i.clamp && sum_w == 64'd0) w1_q <= 64'd1;
      else w1_q <= sum_w;
    end
    if (cmd_i.mul0) prod_q <= {32'b0, w1_q[31:0]} * {33'b0, scale_q};
    if (cmd_i.mul1) acc_q <= ({32'b0, w1_q[63:32]} * {33'b0, scale_q}) + (prod_q >> 32);
    if (cmd_i.norm) begin
      if (w1_q[63]) begin
        x_q <= w1_q[63:32];
        f_q <= '0;
      end else if (w1_q[63:56] == 8'd0) begin
        w1_q <= w1_q << 8;
        n_q  <= n_q + 6'd8;
      end else begin
        w1_q <= w1_q << 1;
        n_q  <= n_q + 6'd1;
      end
    end
    if (cmd_i.log_step) begin
      f_q <= {f_q[28:0], sq_sh[32]};
      x_q <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
    end
    if (cmd_i.len) begin
      l_q  <= ({30'b0, 7'({1'b0, n_q} + 7'd1)} << 30) - {7'b0, f_q};
      cz_q <= $signed({3'b0, zp[62:32]});
      cx_q <= $signed(CORDIC_GAIN_Q30);
      cy_q <= '0;
    end
    if (cmd_i.pmul) begin
      v_q   <= pl[61:18];
      res_q <= '0;
      bit_q <= 44'd1 << 42;
    end
    if (cmd_i.iter) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + at;
      end
      if (cmd_i.sqrt_en) begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
    if (cmd_i.fin0 || cmd_i.fin1) gm_q <= gm_d;
    if (cmd_i.fin1) g1_q <= g_sat;
    if (cmd_i.emit_u) begin
      out_q.result_kind  <= 1'b0;
      out_q.uniform_word <= w1_q;
      out_q.scaled_value <= acc_q[62:32];
      out_q.gauss_first  <= '0;
      out_q.gauss_second <= '0;
    end
    if (cmd_i.emit_g) begin
      out_q.result_kind  <= 1'b1;
      out_q.uniform_word <= '0;
      out_q.scaled_value <= '0;
      out_q.gauss_first  <= g1_q;
      out_q.gauss_second <= g_sat;
    end
  end

  // Hold pointer, scale register and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      scale_q <= 31'd1073741823;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.sum) begin
        ptr_q <= (ptr_q == PW'(RING_DEPTH - 1)) ? '0 : ptr_q + PW'(1);
      end
      if (cfg_valid_i) scale_q <= cfg_data_i;
      valid_q <= cmd_i.emit_u | cmd_i.emit_g;
    end
  end

  assign status_o.norm_done = w1_q[63];
  assign result_valid_o     = valid_q;
  assign result_o           = out_q;

endmodule

[hw/rtl/lagged_fibonacci_gauss_rng.sv]
// Top level of the lagged Fibonacci generator with gaussian output.
// Channel   Handshake                    Payload
// item      start / busy                 item_i (item_t)
// result    result_valid_o strobe        result_o (result_t)
// config    cfg_valid_i / cfg_ready_o    cfg_data_i (uniform_scale)
// The ring RAM's single read port makes each draw read the two lags in turn,
// then write their sum. A gaussian pair takes two draws, a normalization,
// 30 log squaring rounds and 24 CORDIC iterations, one per cycle, of which
// the first 22 also run a square root step.
// The result strobe is high for one cycle after the item finishes; the
// receiver cannot stall it. Reset clears the pointer and sets the scale
// register to 1073741823; the ring must be loaded before it is drawn from.
`include "assert_macros.svh"

module lagged_fibonacci_gauss_rng import lfgr_pkg::*; #(
  parameter int RING_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  lfgr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (item_i.operation),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  lfgr_dpath #(.RING_DEPTH(RING_DEPTH)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assign cfg_ready_o = 1'b1;

  `ASSERT_NEXT(a_strobe_pulse, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `ASSERT_NEXT(a_accept_no_result, clk_i, rst_ni, start && !busy, !result_valid_o)
  `ASSERT_SAME(a_gauss_clear, clk_i, rst_ni, result_valid_o && result_o.result_kind, (result_o.uniform_word == 64'd0) && (result_o.scaled_value == 31'd0))
  `ASSERT_SAME(a_unif_clear, clk_i, rst_ni, result_valid_o && !result_o.result_kind, (result_o.gauss_first == 24'sd0) && (result_o.gauss_second == 24'sd0))

endmodule
